[design/qes_pkg.sv]
// ----------------------------------------------------------------------------
// qes_pkg
// Shared widths, result kinds and sideband records for the quadratic solver.
// ----------------------------------------------------------------------------
package qes_pkg;

    localparam int COEF_W     = 32;
    localparam int TOL_W      = 16;
    localparam int COUNT_W    = 2;
    localparam int PROD_W     = 64;
    localparam int DM_W       = 66;
    localparam int SQ_CELLS   = DM_W / 2;
    localparam int SQ_ROOT_W  = 33;
    localparam int SQ_REM_W   = 35;
    localparam int NUM_W      = 34;
    localparam int DIV_D_W    = 33;

    localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_INF  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_INF,
        KIND_LIN,
        KIND_ONE,
        KIND_TWO
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic                      a_neg;
        logic                      b_neg;
        logic                      b_nz;
        logic                      c_neg;
        logic                      c_nz;
        logic                      c_zero;
        logic signed [COEF_W-1:0]  b;
        logic [COEF_W-1:0]         ma;
        logic [COEF_W-1:0]         mb;
        logic [COEF_W-1:0]         mc;
    } sq_side_t;

    typedef struct packed {
        kind_t kind;
        logic  neg1;
        logic  neg2;
    } div_side_t;

endpackage

[design/qes_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qes_sqrt_cell
// One digit of a restoring square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module qes_sqrt_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [qes_pkg::DM_W-1:0]      rad_in,
    input  logic [qes_pkg::SQ_REM_W-1:0]  rem_in,
    input  logic [qes_pkg::SQ_ROOT_W-1:0] root_in,
    output logic [qes_pkg::DM_W-1:0]      rad_out,
    output logic [qes_pkg::SQ_REM_W-1:0]  rem_out,
    output logic [qes_pkg::SQ_ROOT_W-1:0] root_out
);
    import qes_pkg::*;

    logic [SQ_REM_W+1:0]  rem_wide;
    logic [SQ_REM_W+1:0]  trial;
    logic [SQ_REM_W+1:0]  diff;
    logic                 take;
    logic [DM_W-1:0]      rad_next;
    logic [SQ_REM_W-1:0]  rem_next;
    logic [SQ_ROOT_W-1:0] root_next;
    logic [DM_W-1:0]      rad_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;

    always_comb
    begin
        rem_wide  = {rem_in, rad_in[DM_W-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        diff      = rem_wide - trial;
        take      = (rem_wide >= trial);
        rem_next  = take ? diff[SQ_REM_W-1:0] : rem_wide[SQ_REM_W-1:0];
        root_next = {root_in[SQ_ROOT_W-2:0], take};
        rad_next  = {rad_in[DM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

[design/qes_div_cell.sv]
// ----------------------------------------------------------------------------
// qes_div_cell
// One step of a restoring divider: one numerator bit in, one quotient bit out.
// ----------------------------------------------------------------------------
module qes_div_cell #(
    parameter int NUM_BITS = 50
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [NUM_BITS-1:0]         num_in,
    input  logic [qes_pkg::DIV_D_W-1:0] rem_in,
    input  logic [NUM_BITS-1:0]         quo_in,
    input  logic [qes_pkg::DIV_D_W-1:0] den_in,
    output logic [NUM_BITS-1:0]         num_out,
    output logic [qes_pkg::DIV_D_W-1:0] rem_out,
    output logic [NUM_BITS-1:0]         quo_out,
    output logic [qes_pkg::DIV_D_W-1:0] den_out
);
    import qes_pkg::*;

    logic [DIV_D_W:0]   rem_wide;
    logic [DIV_D_W:0]   diff;
    logic               take;
    logic [NUM_BITS-1:0] num_next;
    logic [DIV_D_W-1:0] rem_next;
    logic [NUM_BITS-1:0] quo_next;
    logic [NUM_BITS-1:0] num_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DIV_D_W-1:0] den_reg;

    always_comb
    begin
        rem_wide = {rem_in, num_in[NUM_BITS-1]};
        diff     = rem_wide - {1'b0, den_in};
        take     = (rem_wide >= {1'b0, den_in});
        rem_next = take ? diff[DIV_D_W-1:0] : rem_wide[DIV_D_W-1:0];
        quo_next = {quo_in[NUM_BITS-2:0], take};
        num_next = {num_in[NUM_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_in;
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign den_out = den_reg;

endmodule

[design/quadratic_equation_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_equation_solver
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries coef_square, coef_linear and coef_constant; it is taken
//   on a clock edge with in_valid high and in_stall low. One result leaves per
//   request on out_valid / out_stall: root_count, first_root, second_root and
//   overflow.
//   zero_tolerance is to be written through cfg_valid / cfg_ready while idle;
//   the block does not enforce this; cfg_ready is always high.
//   From accept to out_valid a request passes three front stages (input,
//   multiply, discriminant), 33 square root cells, one operand stage,
//   34 + FRAC_BITS divider cells and the output register. One request
//   enters every cycle while the pipeline is not stalled.
//   A receiver stall while out_valid is high holds the output register and
//   freezes the whole pipeline; in_stall follows it in the same cycle.
//   Reset empties the pipeline and sets zero_tolerance to 1.
// ----------------------------------------------------------------------------
module quadratic_equation_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [qes_pkg::COEF_W-1:0]    coef_square,
    input  logic signed [qes_pkg::COEF_W-1:0]    coef_linear,
    input  logic signed [qes_pkg::COEF_W-1:0]    coef_constant,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [qes_pkg::COUNT_W-1:0]          root_count,
    output logic signed [qes_pkg::COEF_W-1:0]    first_root,
    output logic signed [qes_pkg::COEF_W-1:0]    second_root,
    output logic                                 overflow,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qes_pkg::TOL_W-1:0]            zero_tolerance
);
    import qes_pkg::*;

    localparam int NUM_BITS = NUM_W + FRAC_BITS;
    localparam logic [NUM_BITS-1:0] NEG_LIM = {{(NUM_BITS-32){1'b0}}, 32'h8000_0000};
    localparam logic [NUM_BITS-1:0] POS_LIM = {{(NUM_BITS-32){1'b0}}, 32'h7FFF_FFFF};

    logic                 adv;
    logic [TOL_W-1:0]     tol_reg;

    logic                 s0_valid_reg;
    logic signed [COEF_W-1:0] a_reg, b_reg, c_reg;

    logic [COEF_W-1:0]    ma_next, mb_next, mc_next;
    logic                 s1_valid_reg;
    logic                 a_neg_reg, b_neg_reg, c_neg_reg;
    logic                 az_reg, bz_reg, cz_reg;
    logic signed [COEF_W-1:0] b1_reg;
    logic [COEF_W-1:0]    ma_reg, mb_reg, mc_reg;
    logic [PROD_W-1:0]    bb_reg, amc_reg;

    logic [DM_W-1:0]      p_w, bb_w, sum_w, d1_w, d2_w, dm_next, thr_w;
    logic                 opp, ge, dneg;
    sq_side_t             side_next;
    logic [DM_W-1:0]      s2_dm_reg;

    logic                 sq_valid_reg [0:SQ_CELLS];
    sq_side_t             sq_side_reg  [0:SQ_CELLS];
    logic [DM_W-1:0]      sq_rad  [0:SQ_CELLS];
    logic [SQ_REM_W-1:0]  sq_rem  [0:SQ_CELLS];
    logic [SQ_ROOT_W-1:0] sq_root [0:SQ_CELLS];

    sq_side_t             fs;
    logic [SQ_ROOT_W-1:0] s_root;
    logic signed [NUM_W:0] bx, sx, n1, n2;
    logic [NUM_W-1:0]     n1m, n2m, num1_next, num2_next;
    logic [DIV_D_W-1:0]   den_next, two_a;
    div_side_t            dside_next;
    logic [NUM_W-1:0]     num1_reg, num2_reg;
    logic [DIV_D_W-1:0]   den_reg;

    logic                 dv_valid_reg [0:NUM_BITS];
    div_side_t            dv_side_reg  [0:NUM_BITS];
    logic [NUM_BITS-1:0]  d1_num [0:NUM_BITS];
    logic [DIV_D_W-1:0]   d1_rem [0:NUM_BITS];
    logic [NUM_BITS-1:0]  d1_quo [0:NUM_BITS];
    logic [DIV_D_W-1:0]   d1_den [0:NUM_BITS];
    logic [NUM_BITS-1:0]  d2_num [0:NUM_BITS];
    logic [DIV_D_W-1:0]   d2_rem [0:NUM_BITS];
    logic [NUM_BITS-1:0]  d2_quo [0:NUM_BITS];
    logic [DIV_D_W-1:0]   d2_den [0:NUM_BITS];

    div_side_t            ls;
    logic [COEF_W:0]      fix1, fix2;
    logic                 fz;
    logic [COUNT_W-1:0]   count_next;
    logic [COEF_W-1:0]    r1_next, r2_next;
    logic                 ovf_next;

    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   root_count_reg;
    logic [COEF_W-1:0]    first_root_reg, second_root_reg;
    logic                 overflow_reg;

    function automatic logic [COEF_W:0] fix_root(
        input logic                neg,
        input logic [NUM_BITS-1:0] q,
        input logic [TOL_W-1:0]    tol,
        input logic                force_z
    );
        logic [COEF_W-1:0] r;
        logic [COEF_W-1:0] m;
        logic              o;
        o = 1'b0;
        if (neg)
        begin
            if (q > NEG_LIM)
            begin
                o = 1'b1;
                r = 32'h8000_0000;
                m = 32'h8000_0000;
            end
            else
            begin
                r = -q[COEF_W-1:0];
                m = q[COEF_W-1:0];
            end
        end
        else
        begin
            if (q > POS_LIM)
            begin
                o = 1'b1;
                r = 32'h7FFF_FFFF;
                m = 32'h7FFF_FFFF;
            end
            else
            begin
                r = q[COEF_W-1:0];
                m = q[COEF_W-1:0];
            end
        end
        if (force_z && ((m == '0) || (m < {{(COEF_W-TOL_W){1'b0}}, tol})))
        begin
            r = '0;
        end
        return {o, r};
    endfunction

    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_W'(1);
        end
        else if (cfg_valid)
        begin
            tol_reg <= zero_tolerance;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            a_reg <= coef_square;
            b_reg <= coef_linear;
            c_reg <= coef_constant;
        end
    end

    // magnitudes and products
    always_comb
    begin
        ma_next = a_reg[COEF_W-1] ? (~a_reg + 1'b1) : a_reg;
        mb_next = b_reg[COEF_W-1] ? (~b_reg + 1'b1) : b_reg;
        mc_next = c_reg[COEF_W-1] ? (~c_reg + 1'b1) : c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_neg_reg <= a_reg[COEF_W-1];
            b_neg_reg <= b_reg[COEF_W-1];
            c_neg_reg <= c_reg[COEF_W-1];
            az_reg    <= (ma_next == '0) || (ma_next < {{(COEF_W-TOL_W){1'b0}}, tol_reg});
            bz_reg    <= (mb_next == '0) || (mb_next < {{(COEF_W-TOL_W){1'b0}}, tol_reg});
            cz_reg    <= (mc_next == '0) || (mc_next < {{(COEF_W-TOL_W){1'b0}}, tol_reg});
            b1_reg    <= b_reg;
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            mc_reg    <= mc_next;
            bb_reg    <= mb_next * mb_next;
            amc_reg   <= ma_next * mc_next;
        end
    end

    // discriminant and classification
    always_comb
    begin
        p_w   = {amc_reg, 2'b00};
        bb_w  = {2'b00, bb_reg};
        thr_w = {{(DM_W-TOL_W){1'b0}}, tol_reg} << FRAC_BITS;
        opp   = (mc_reg != '0) && (a_neg_reg != c_neg_reg);
        sum_w = bb_w + p_w;
        d1_w  = bb_w - p_w;
        d2_w  = p_w - bb_w;
        ge    = (bb_w >= p_w);
        dneg  = !opp && !ge;
        dm_next = opp ? sum_w : (ge ? d1_w : d2_w);

        side_next.a_neg  = a_neg_reg;
        side_next.b_neg  = b_neg_reg;
        side_next.b_nz   = (mb_reg != '0);
        side_next.c_neg  = c_neg_reg;
        side_next.c_nz   = (mc_reg != '0);
        side_next.c_zero = cz_reg;
        side_next.b      = b1_reg;
        side_next.ma     = ma_reg;
        side_next.mb     = mb_reg;
        side_next.mc     = mc_reg;

        if (az_reg)
        begin
            if (bz_reg)
                side_next.kind = cz_reg ? KIND_INF : KIND_NONE;
            else
                side_next.kind = KIND_LIN;
        end
        else if ((dm_next == '0) || (dm_next < thr_w))
            side_next.kind = KIND_ONE;
        else if (!dneg && (dm_next > thr_w))
            side_next.kind = KIND_TWO;
        else
            side_next.kind = KIND_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dm_reg      <= dm_next;
            sq_side_reg[0] <= side_next;
        end
    end

    // square root chain
    assign sq_rad[0]  = s2_dm_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= s1_valid_reg;
        end
    end

    for (genvar k = 0; k < SQ_CELLS; k++)
    begin : g_sq
        qes_sqrt_cell u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // divider operands
    always_comb
    begin
        fs     = sq_side_reg[SQ_CELLS];
        s_root = fs.c_zero ? {1'b0, fs.mb} : sq_root[SQ_CELLS];
        bx     = (NUM_W+1)'(fs.b);
        sx     = {2'b00, s_root};
        n1     = -bx - sx;
        n2     = -bx + sx;
        n1m    = n1[NUM_W] ? NUM_W'(-n1) : n1[NUM_W-1:0];
        n2m    = n2[NUM_W] ? NUM_W'(-n2) : n2[NUM_W-1:0];
        two_a  = {fs.ma, 1'b0};

        dside_next.kind = fs.kind;
        dside_next.neg1 = 1'b0;
        dside_next.neg2 = 1'b0;
        num1_next = '0;
        num2_next = '0;
        den_next  = DIV_D_W'(1);

        unique case (fs.kind)
            KIND_LIN:
            begin
                num1_next = {2'b00, fs.mc};
                den_next  = {1'b0, fs.mb};
                dside_next.neg1 = (fs.c_neg == fs.b_neg) && fs.c_nz;
            end
            KIND_ONE:
            begin
                num1_next = {2'b00, fs.mb};
                den_next  = two_a;
                dside_next.neg1 = ((fs.b_nz && !fs.b_neg) != fs.a_neg) && fs.b_nz;
            end
            KIND_TWO:
            begin
                num1_next = n1m;
                num2_next = n2m;
                den_next  = two_a;
                dside_next.neg1 = (n1 != '0) && (n1[NUM_W] != fs.a_neg);
                dside_next.neg2 = (n2 != '0) && (n2[NUM_W] != fs.a_neg);
            end
            KIND_NONE, KIND_INF:
            begin
                num1_next = '0;
            end
            default:
            begin
                num1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg       <= num1_next;
            num2_reg       <= num2_next;
            den_reg        <= den_next;
            dv_side_reg[0] <= dside_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= sq_valid_reg[SQ_CELLS];
        end
    end

    // divider chains
    assign d1_num[0] = {num1_reg, {FRAC_BITS{1'b0}}};
    assign d1_rem[0] = '0;
    assign d1_quo[0] = '0;
    assign d1_den[0] = den_reg;
    assign d2_num[0] = {num2_reg, {FRAC_BITS{1'b0}}};
    assign d2_rem[0] = '0;
    assign d2_quo[0] = '0;
    assign d2_den[0] = den_reg;

    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_dv
        qes_div_cell #(.NUM_BITS(NUM_BITS)) u_div1 (
            .clk     (clk),
            .en      (adv),
            .num_in  (d1_num[k]),
            .rem_in  (d1_rem[k]),
            .quo_in  (d1_quo[k]),
            .den_in  (d1_den[k]),
            .num_out (d1_num[k+1]),
            .rem_out (d1_rem[k+1]),
            .quo_out (d1_quo[k+1]),
            .den_out (d1_den[k+1])
        );

        qes_div_cell #(.NUM_BITS(NUM_BITS)) u_div2 (
            .clk     (clk),
            .en      (adv),
            .num_in  (d2_num[k]),
            .rem_in  (d2_rem[k]),
            .quo_in  (d2_quo[k]),
            .den_in  (d2_den[k]),
            .num_out (d2_num[k+1]),
            .rem_out (d2_rem[k+1]),
            .quo_out (d2_quo[k+1]),
            .den_out (d2_den[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // saturate, force to zero, assemble
    always_comb
    begin
        ls   = dv_side_reg[NUM_BITS];
        fz   = (ls.kind == KIND_ONE) || (ls.kind == KIND_TWO);
        fix1 = fix_root(ls.neg1, d1_quo[NUM_BITS], tol_reg, fz);
        fix2 = fix_root(ls.neg2, d2_quo[NUM_BITS], tol_reg, fz);
        count_next = COUNT_NONE;
        r1_next    = '0;
        r2_next    = '0;
        ovf_next   = 1'b0;
        unique case (ls.kind)
            KIND_INF:
            begin
                count_next = COUNT_INF;
            end
            KIND_LIN, KIND_ONE:
            begin
                count_next = COUNT_ONE;
                r1_next    = fix1[COEF_W-1:0];
                ovf_next   = fix1[COEF_W];
            end
            KIND_TWO:
            begin
                count_next = COUNT_TWO;
                r1_next    = fix1[COEF_W-1:0];
                r2_next    = fix2[COEF_W-1:0];
                ovf_next   = fix1[COEF_W] | fix2[COEF_W];
            end
            KIND_NONE:
            begin
                count_next = COUNT_NONE;
            end
            default:
            begin
                count_next = COUNT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[NUM_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_count_reg  <= count_next;
            first_root_reg  <= r1_next;
            second_root_reg <= r2_next;
            overflow_reg    <= ovf_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_count  = root_count_reg;
    assign first_root  = first_root_reg;
    assign second_root = second_root_reg;
    assign overflow    = overflow_reg;

endmodule
